// ----- hdl/target_matching_message_queue_defines.svh -----
// Assertion macros shared by the target matching message queue RTL.
`ifndef TARGET_MATCHING_MESSAGE_QUEUE_DEFINES_SVH
`define TARGET_MATCHING_MESSAGE_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every clock edge outside reset.
`define TMQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tmq assertion failed");
// Next-cycle implication checked at every clock edge outside reset.
`define TMQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tmq assertion failed");
`else
`define TMQ_ASSERT_IMP(label, ante, cons)
`define TMQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/tmq_pkg.sv -----
// Types and constants for the target matching message queue.
package tmq_pkg;

    // Operation codes carried in the request.
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_PEEK = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    // Control states of the sequencer.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    // One request.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] dest_id;
        logic [1:0]         target_kind;
        logic [31:0]        payload_word;
    } t_req;

    // One response.
    typedef struct packed {
        logic               found;
        logic               failed;
        logic signed [31:0] out_id;
        logic [1:0]         out_kind;
        logic [31:0]        out_payload;
        logic [4:0]         total_count;
        logic [4:0]         id_count;
    } t_rsp;

endpackage

// ----- hdl/target_matching_message_queue.sv -----
// Target matching message queue: ordered message store with id search and pop.
//
// Usage: requests enter on i_req_valid/o_req_ready and carry an op (add, peek,
// pop), a target id, a kind and a payload word. Each request gives exactly one
// response on o_rsp_valid/i_rsp_ready with the returned message, found and
// failed flags, the message count and the count for the requested id.
// Every request scans the stored messages through the memory's read port, one
// entry per cycle through a registered read, before its response enters the
// output register. A pop that removes a message which is not the newest then
// closes the gap, since the same port moves each later message down one place,
// one at a time. One request is in work at a time, and the next one is taken
// the cycle after a response enters the output register.
// A finished response waits in the output register; the block takes the next
// request while it waits, and holds a later result internally until the
// output register is free, so a stalled receiver stops the block cleanly.
// Reset empties the store at once by clearing the fill level; memory contents
// are not cleared and entries above the fill level are never read.
module target_matching_message_queue
    import tmq_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

`include "target_matching_message_queue_defines.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = PAYLOAD_BITS;

    typedef struct packed {
        logic [31:0]   id;
        logic [1:0]    kind;
        logic [PW-1:0] pay;
    } t_entry;

    // Message memory and its ports.
    t_entry          mem [DEPTH];
    t_entry          r_rd_data;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_entry          mem_wdata;

    // Control and working registers.
    t_state          r_state, n_state;
    t_req            r_req, n_req;
    logic [CW-1:0]   r_fill, n_fill;
    logic [CW-1:0]   r_iss, n_iss;
    logic            r_rd_vld, n_rd_vld;
    logic [AW-1:0]   r_rd_idx, n_rd_idx;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_hit_vld, n_hit_vld;
    logic [AW-1:0]   r_hit_idx, n_hit_idx;
    t_entry          r_hit, n_hit;
    t_entry          r_first, n_first;
    t_rsp            r_res, n_res;
    logic            r_out_vld, n_out_vld;
    t_rsp            r_out, n_out;

    logic            scan_done;
    logic            out_free;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;
    assign scan_done   = (r_iss == r_fill) && !r_rd_vld;
    assign out_free    = !r_out_vld || i_rsp_ready;

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_iss     <= '0;
            r_rd_vld  <= 1'b0;
            r_cnt     <= '0;
            r_hit_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_iss     <= n_iss;
            r_rd_vld  <= n_rd_vld;
            r_cnt     <= n_cnt;
            r_hit_vld <= n_hit_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_rd_idx  <= n_rd_idx;
        r_hit_idx <= n_hit_idx;
        r_hit     <= n_hit;
        r_first   <= n_first;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    // Sequencer: scan, decide, close the gap, hand over the response.
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_fill    = r_fill;
        n_iss     = r_iss;
        n_rd_vld  = 1'b0;
        n_rd_idx  = r_rd_idx;
        n_cnt     = r_cnt;
        n_hit_vld = r_hit_vld;
        n_hit_idx = r_hit_idx;
        n_hit     = r_hit;
        n_first   = r_first;
        n_res     = r_res;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        mem_re    = 1'b0;
        mem_raddr = r_iss[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_fill[AW-1:0];
        mem_wdata = '{id: r_req.dest_id, kind: r_req.target_kind,
                      pay: PW'(r_req.payload_word)};

        // The output register drains independently of the sequencer.
        if (r_out_vld && i_rsp_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req     = i_req;
                    n_iss     = '0;
                    n_cnt     = '0;
                    n_hit_vld = 1'b0;
                    n_state   = S_SCAN;
                end
            end

            S_SCAN: begin
                // Issue the next read while entries remain.
                if (r_iss != r_fill) begin
                    mem_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_iss[AW-1:0];
                    n_iss    = r_iss + CW'(1);
                end
                // Inspect the entry read in the previous cycle.
                if (r_rd_vld) begin
                    if (r_rd_data.id == r_req.dest_id) begin
                        n_cnt = r_cnt + CW'(1);
                        if (!r_hit_vld) begin
                            n_hit_vld = 1'b1;
                            n_hit_idx = r_rd_idx;
                            n_hit     = r_rd_data;
                        end
                    end
                    if (r_rd_idx == '0) begin
                        n_first = r_rd_data;
                    end
                end
                // All entries seen: apply the operation and form the response.
                if (scan_done) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    case (r_req.op)
                        OP_ADD: begin
                            if (r_fill == CW'(DEPTH)) begin
                                n_res.failed = 1'b1;
                            end else begin
                                mem_we = 1'b1;
                                n_fill = r_fill + CW'(1);
                                n_cnt  = r_cnt + CW'(1);
                            end
                        end
                        OP_PEEK, OP_POP: begin
                            if (r_fill == '0) begin
                                n_res.failed = 1'b1;
                            end else if (r_hit_vld) begin
                                n_res.found       = 1'b1;
                                n_res.out_id      = $signed(r_hit.id);
                                n_res.out_kind    = r_hit.kind;
                                n_res.out_payload = 32'(r_hit.pay);
                                if (r_req.op == OP_POP) begin
                                    n_fill = r_fill - CW'(1);
                                    n_cnt  = r_cnt - CW'(1);
                                    if (CW'(r_hit_idx) + CW'(1) < r_fill) begin
                                        n_iss   = CW'(r_hit_idx) + CW'(1);
                                        n_state = S_SHIFT;
                                    end
                                end
                            end else begin
                                n_res.out_id      = $signed(r_first.id);
                                n_res.out_kind    = r_first.kind;
                                n_res.out_payload = 32'(r_first.pay);
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res.total_count = 5'(n_fill);
                    n_res.id_count    = 5'(n_cnt);
                end
            end

            S_SHIFT: begin
                // Read each later entry and write it one place lower.
                if (r_iss <= r_fill) begin
                    mem_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_iss[AW-1:0];
                    n_iss    = r_iss + CW'(1);
                end
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_idx - AW'(1);
                    mem_wdata = r_rd_data;
                end
                if ((r_iss > r_fill) && !r_rd_vld) begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Checks on the sequencer.
    `TMQ_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= CW'(DEPTH))
    `TMQ_ASSERT_NEXT(a_accept_starts_scan, i_req_valid && o_req_ready,
                     r_state == S_SCAN && r_cnt == '0 && !r_hit_vld)
    `TMQ_ASSERT_IMP(a_shift_write_range, r_state == S_SHIFT && mem_we,
                    mem_waddr >= r_hit_idx && CW'(mem_waddr) < r_fill)
    `TMQ_ASSERT_NEXT(a_done_loads_output, r_state == S_DONE && out_free,
                     r_out_vld && r_state == S_IDLE)
    `TMQ_ASSERT_IMP(a_hit_counted, r_state == S_SCAN && r_hit_vld, r_cnt != '0)

endmodule

// ----- tb/target_matching_message_queue_test.sv -----
// Self-checking testbench for the target matching message queue.
module target_matching_message_queue_test
    import tmq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int SCAN_LATENCY = 2 * DEPTH + 4;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 244;
    localparam int CHOKE_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    // The op field has one code that the block must treat as a no-op.
    localparam logic [1:0] OP_NONE = 2'd3;

    // One line of the directed plan; fixed rows carry their response by hand.
    typedef struct {
        t_req req;
        int   reps;
        bit   fixed;
        t_rsp rsp;
    } t_row;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp;

    // Messages the block should hold, oldest first.
    logic signed [31:0] held_id [DEPTH];
    logic [1:0]         held_kind [DEPTH];
    logic [31:0]        held_payload [DEPTH];
    int                 held_count = 0;

    t_rsp        awaited_rsp [$];
    t_row        plan_rows [$];
    logic [31:0] id_pool [4];
    int          mismatches    = 0;
    int unsigned cycle_count   = 0;
    bit          calm          = 1'b0;
    bit          choke_pending = 1'b0;

    target_matching_message_queue u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    // 50 MHz clock.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Apply one request to the expected store and return its response.
    function automatic t_rsp apply_request(t_req r);
        t_rsp res;
        int   hit;
        int   id_hits;
        res = '0;
        hit = -1;
        id_hits = 0;
        case (r.op)
            OP_ADD: begin
                if (held_count >= DEPTH) begin
                    res.failed = 1'b1;
                end else begin
                    held_id[held_count]      = r.dest_id;
                    held_kind[held_count]    = r.target_kind;
                    held_payload[held_count] = r.payload_word;
                    held_count++;
                end
            end
            OP_PEEK, OP_POP: begin
                if (held_count == 0) begin
                    res.failed = 1'b1;
                end else begin
                    for (int i = 0; i < held_count; i++) begin
                        if (hit < 0 && held_id[i] == r.dest_id) begin
                            hit = i;
                        end
                    end
                    // Without a match the oldest message is shown and kept.
                    res.found       = (hit >= 0);
                    if (hit < 0) begin
                        hit = 0;
                    end
                    res.out_id      = held_id[hit];
                    res.out_kind    = held_kind[hit];
                    res.out_payload = held_payload[hit];
                    if (res.found && r.op == OP_POP) begin
                        for (int i = hit; i + 1 < held_count; i++) begin
                            held_id[i]      = held_id[i + 1];
                            held_kind[i]    = held_kind[i + 1];
                            held_payload[i] = held_payload[i + 1];
                        end
                        held_count--;
                    end
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < held_count; i++) begin
            if (held_id[i] == r.dest_id) begin
                id_hits++;
            end
        end
        res.total_count = 5'(held_count);
        res.id_count    = 5'(id_hits);
        return res;
    endfunction

    // Offer one request, wait for it to be taken, then record what it should return.
    task automatic send_request(t_req r, bit fixed, t_rsp fixed_rsp);
        int   idle;
        t_rsp want;
        idle = pick_gap();
        if (idle > 0) begin
            req_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        want = apply_request(r);
        awaited_rsp.insert(awaited_rsp.size(), fixed ? fixed_rsp : want);
    endtask

    // Compare one response with the oldest outstanding expectation.
    task automatic check_response(t_rsp got);
        t_rsp want;
        if (awaited_rsp.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
            return;
        end
        want = awaited_rsp.pop_front();
        if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatches++;
        end
        if (got.failed !== want.failed) begin
            $error("failed: expected %0d, got %0d", want.failed, got.failed);
            mismatches++;
        end
        if (got.out_id !== want.out_id) begin
            $error("out_id: expected %0d, got %0d", want.out_id, got.out_id);
            mismatches++;
        end
        if (got.out_kind !== want.out_kind) begin
            $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
            mismatches++;
        end
        if (got.out_payload !== want.out_payload) begin
            $error("out_payload: expected %h, got %h", want.out_payload, got.out_payload);
            mismatches++;
        end
        if (got.total_count !== want.total_count) begin
            $error("total_count: expected %0d, got %0d", want.total_count, got.total_count);
            mismatches++;
        end
        if (got.id_count !== want.id_count) begin
            $error("id_count: expected %0d, got %0d", want.id_count, got.id_count);
            mismatches++;
        end
    endtask

    // Append one row to the directed plan.
    function automatic void add_row(t_row row);
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    function automatic t_row plan_row(logic [1:0] op, logic signed [31:0] id,
                                      logic [1:0] kind, logic [31:0] payload, int reps);
        t_row row;
        row.req.op           = op;
        row.req.dest_id      = id;
        row.req.target_kind  = kind;
        row.req.payload_word = payload;
        row.reps             = reps;
        row.fixed            = 1'b0;
        row.rsp              = '0;
        return row;
    endfunction

    // A row whose response has nothing returned, only flags and counts.
    function automatic t_row known_row(logic [1:0] op, logic signed [31:0] id,
                                       logic [1:0] kind, logic [31:0] payload,
                                       logic failed, logic [4:0] total, logic [4:0] idc);
        t_row row;
        row                 = plan_row(op, id, kind, payload, 1);
        row.fixed           = 1'b1;
        row.rsp.failed      = failed;
        row.rsp.total_count = total;
        row.rsp.id_count    = idc;
        return row;
    endfunction

    // Random request; most ids come from a small pool so that searches hit.
    function automatic t_req random_request(int add_pct);
        t_req r;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            r.op = OP_NONE;
        end else if (roll < 3 + add_pct) begin
            r.op = OP_ADD;
        end else begin
            r.op = $urandom_range(0, 1) ? OP_PEEK : OP_POP;
        end
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            r.dest_id = id_pool[$urandom_range(0, 3)];
        end else if (roll < 88) begin
            r.dest_id = id_pool[$urandom_range(0, 3)] ^ (32'h1 << $urandom_range(0, 31));
        end else begin
            r.dest_id = $urandom;
        end
        r.target_kind  = 2'($urandom_range(0, 3));
        r.payload_word = $urandom;
        return r;
    endfunction

    // Response side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (rsp_valid && rsp_ready) begin
                check_response(rsp);
            end
            if (choke_pending) begin
                choke_pending = 1'b0;
                stall = CHOKE_CYCLES;
            end
            if (stall > 0) begin
                rsp_ready <= 1'b0;
                stall--;
            end else begin
                rsp_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Request side: directed plan, then random phases.
    initial begin
        t_row row;
        t_req r;
        int   add_mix [PHASES];
        add_mix = '{65, 35, 85, 20, 50, 90, 10, 50};

        // Empty store: searches fail, the unused code only reports counts.
        add_row(known_row(OP_PEEK, 32'sd0, 2'd0, 32'h0, 1'b1, 5'd0, 5'd0));
        add_row(known_row(OP_POP, -32'sd1, 2'd3, 32'hffff_ffff, 1'b1, 5'd0, 5'd0));
        add_row(known_row(OP_NONE, 32'sd0, 2'd0, 32'h0, 1'b0, 5'd0, 5'd0));
        // Fill to the brim with extreme ids and payloads, then overflow.
        add_row(known_row(OP_ADD, 32'sh8000_0000, 2'd3, 32'hffff_ffff,
                          1'b0, 5'd1, 5'd1));
        add_row(known_row(OP_ADD, 32'sh7fff_ffff, 2'd0, 32'h0, 1'b0, 5'd2, 5'd1));
        add_row(plan_row(OP_ADD, 32'sd7, 2'd1, 32'ha5a5_a5a5, DEPTH - 2));
        add_row(known_row(OP_ADD, 32'sd9, 2'd2, 32'h1234_5678, 1'b1, 5'd16, 5'd0));
        // Hit, miss, middle pop, oldest pop, no-op with content, pop with no match.
        add_row(plan_row(OP_PEEK, 32'sh7fff_ffff, 2'd0, 32'h0, 1));
        add_row(plan_row(OP_PEEK, 32'sd123, 2'd0, 32'h0, 1));
        add_row(plan_row(OP_POP, 32'sd7, 2'd0, 32'h0, 1));
        add_row(plan_row(OP_POP, 32'sh8000_0000, 2'd0, 32'h0, 1));
        add_row(plan_row(OP_NONE, 32'sd7, 2'd0, 32'h0, 1));
        add_row(plan_row(OP_POP, 32'sd55, 2'd0, 32'h0, 1));
        // Pop the newest message, which needs no gap closing.
        add_row(plan_row(OP_ADD, 32'sh1234_5678, 2'd2, 32'h5a5a_5a5a, 1));
        add_row(plan_row(OP_POP, 32'sh1234_5678, 2'd0, 32'h0, 1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_rows[i]) begin
            row = plan_rows[i];
            for (int k = 0; k < row.reps; k++) begin
                r = row.req;
                r.payload_word = row.req.payload_word + k;
                send_request(r, row.fixed, row.rsp);
            end
        end
        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge clk);

        // Random phases with different add and search mixes.
        for (int phase = 0; phase < PHASES; phase++) begin
            calm = (phase == 3) || (phase == 6);
            foreach (id_pool[k]) begin
                id_pool[k] = $urandom;
            end
            id_pool[0] = phase[0] ? 32'h8000_0000 : 32'h7fff_ffff;
            // Stall the response side while a fill-heavy phase keeps sending.
            if (phase == 2) begin
                choke_pending = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                send_request(random_request(add_mix[phase]), 1'b0, '0);
            end
            req_valid <= 1'b0;
            // Hold the next phase until every response is back.
            while (awaited_rsp.size() != 0) @(posedge clk);
        end

        repeat (2 * SCAN_LATENCY) @(posedge clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tmq_pkg.sv
hdl/target_matching_message_queue.sv
tb/target_matching_message_queue_test.sv
